>>> sv/lpc_pkg.sv
// Shared types and constants of the lidar point colorizer.
// No dependencies; lpc_front, the top level and the testbench refer to it by scoped names.
package lpc_pkg;

    // Item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_POINT = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_PROJ_R0_C01 = 3'd0;
    localparam logic [2:0] CFG_PROJ_R0_C23 = 3'd1;
    localparam logic [2:0] CFG_PROJ_R1_C01 = 3'd2;
    localparam logic [2:0] CFG_PROJ_R1_C23 = 3'd3;
    localparam logic [2:0] CFG_PROJ_R2_C01 = 3'd4;
    localparam logic [2:0] CFG_PROJ_R2_C23 = 3'd5;
    localparam logic [2:0] CFG_PROJ_LAST   = CFG_PROJ_R2_C23;
    localparam logic [2:0] CFG_WIDTH       = 3'd6;
    localparam logic [2:0] CFG_HEIGHT      = 3'd7;

    // Reset values of the image size registers
    localparam logic [10:0] WIDTH_RESET  = 11'd1024;
    localparam logic [9:0]  HEIGHT_RESET = 10'd512;

    // Width of the projected sums U, V, W (Q.16, signed)
    localparam int SUM_W = 51;

    // Depth of the queue between front and back
    localparam int QDEPTH = 32;

    // Side information carried with an item through the front pipeline
    typedef struct packed {
        logic        kind;
        logic [9:0]  col;
        logic [8:0]  row;
        logic [23:0] rgb;
        logic        origin;
        logic        wzero;
        logic        dneg;
        logic        su;
        logic        sv;
        logic        sw;
    } meta_t;

endpackage

>>> sv/lpc_fifo.sv
// Short item queue between the projection front and the image back end.
// Uses lpc_pkg only through its users; generic width and depth.
module lpc_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         not_empty
);
    localparam int PW = $clog2(DEPTH);

    logic [W-1:0]  mem_q [DEPTH];
    logic [PW-1:0] wptr_reg;
    logic [PW-1:0] rptr_reg;
    logic [PW:0]   cnt_reg;
    logic [PW:0]   cnt_next;

    // Store pushed items
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_q[wptr_reg] <= din;
        end
    end

    // Advance pointers and fill count
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    assign dout      = mem_q[rptr_reg];
    assign not_empty = (cnt_reg != '0);

    // Never overrun nor underrun
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> cnt_reg < (PW+1)'(DEPTH))
        else $error("queue overrun");
    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != '0)
        else $error("queue underrun");

endmodule

>>> sv/lpc_front.sv
// Front part: configuration registers, projection, pipelined division, classification.
// Depends on lpc_pkg.
module lpc_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 512,
    parameter int AW         = 19,
    parameter int EW         = 46
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic                acc,
    input  logic                kind,
    input  logic [9:0]          pixel_col,
    input  logic [8:0]          pixel_row,
    input  logic [7:0]          pixel_red,
    input  logic [7:0]          pixel_green,
    input  logic [7:0]          pixel_blue,
    input  logic signed [31:0]  point_x,
    input  logic signed [31:0]  point_y,
    input  logic signed [31:0]  point_z,
    output logic                push,
    output logic [EW-1:0]       entry
);
    localparam int SW   = lpc_pkg::SUM_W;
    localparam int MAXD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int QB   = $clog2(MAXD);
    localparam int DW   = SW + QB;

    // Configuration registers
    logic [63:0] proj_reg [6];
    logic [10:0] iw_reg;
    logic [9:0]  ih_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                proj_reg[i] <= '0;
            end
            iw_reg <= lpc_pkg::WIDTH_RESET;
            ih_reg <= lpc_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index) inside
                [lpc_pkg::CFG_PROJ_R0_C01:lpc_pkg::CFG_PROJ_LAST]:
                                               proj_reg[cfg_index] <= cfg_data;
                lpc_pkg::CFG_WIDTH:            iw_reg <= cfg_data[10:0];
                lpc_pkg::CFG_HEIGHT:           ih_reg <= cfg_data[9:0];
                default:                       iw_reg <= iw_reg;
            endcase
        end
    end

    function automatic logic signed [31:0] coef(input logic [63:0] lo_reg,
                                                input logic [63:0] hi_reg,
                                                input int c);
        logic [63:0] r;
        r = (c < 2) ? lo_reg : hi_reg;
        return (c % 2 == 1) ? $signed(r[63:32]) : $signed(r[31:0]);
    endfunction

    function automatic logic signed [63:0] mul64(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] ae;
        logic signed [63:0] be;
        ae = a;
        be = b;
        return ae * be;
    endfunction

    // Stage 0: hold the accepted item
    logic                s0_vld_reg;
    lpc_pkg::meta_t      s0_meta_reg;
    logic signed [31:0]  s0_crd_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
        end
        else
        begin
            s0_vld_reg <= acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s0_meta_reg   <= '{kind: kind, col: pixel_col, row: pixel_row,
                               rgb: {pixel_red, pixel_green, pixel_blue}, default: '0};
            s0_crd_reg[0] <= point_x;
            s0_crd_reg[1] <= point_y;
            s0_crd_reg[2] <= point_z;
        end
    end

    // Stage 1: nine products
    logic               s1_vld_reg;
    lpc_pkg::meta_t     s1_meta_reg;
    lpc_pkg::meta_t     s1_meta_next;
    logic signed [63:0] s1_p_reg [3][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s0_vld_reg;
        end
    end

    // Flag the point at the origin
    always_comb
    begin
        s1_meta_next        = s0_meta_reg;
        s1_meta_next.origin = (s0_crd_reg[0] == '0) && (s0_crd_reg[1] == '0)
                              && (s0_crd_reg[2] == '0);
    end

    always_ff @(posedge clk)
    begin
        s1_meta_reg <= s1_meta_next;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                s1_p_reg[r][c] <= mul64(coef(proj_reg[2*r], proj_reg[2*r+1], c),
                                        s0_crd_reg[c]);
            end
        end
    end

    // Stage 2: floor products to Q.16 and sum with the offset column
    logic                s2_vld_reg;
    lpc_pkg::meta_t      s2_meta_reg;
    logic signed [SW-1:0] s2_sum_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_meta_reg <= s1_meta_reg;
        for (int r = 0; r < 3; r++)
        begin
            s2_sum_reg[r] <= SW'(s1_p_reg[r][0] >>> 16) + SW'(s1_p_reg[r][1] >>> 16)
                           + SW'(s1_p_reg[r][2] >>> 16)
                           + SW'(coef(proj_reg[2*r], proj_reg[2*r+1], 3));
        end
    end

    // Stage 3: signs, magnitudes, zero and depth checks
    logic                s3_vld_reg;
    lpc_pkg::meta_t      s3_meta_reg;
    lpc_pkg::meta_t      s3_meta_next;
    logic [SW-1:0]       s3_mag_reg [3];
    logic [SW:0]         dchk;

    assign dchk = (SW+1)'(s2_sum_reg[2]) + (SW+1)'(65535);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    // Classify W and record the signs of the sums
    always_comb
    begin
        s3_meta_next       = s2_meta_reg;
        s3_meta_next.wzero = (s2_sum_reg[2] == '0);
        s3_meta_next.dneg  = dchk[SW];
        s3_meta_next.su    = s2_sum_reg[0][SW-1];
        s3_meta_next.sv    = s2_sum_reg[1][SW-1];
        s3_meta_next.sw    = s2_sum_reg[2][SW-1];
    end

    always_ff @(posedge clk)
    begin
        s3_meta_reg <= s3_meta_next;
        for (int r = 0; r < 3; r++)
        begin
            s3_mag_reg[r] <= s2_sum_reg[r][SW-1] ? SW'(-s2_sum_reg[r]) : SW'(s2_sum_reg[r]);
        end
    end

    // Division stages: one quotient bit of U/W and V/W each per stage
    logic                 dv_vld_reg  [QB];
    lpc_pkg::meta_t       dv_meta_reg [QB];
    logic [SW-1:0]        dv_d_reg    [QB];
    logic [DW-1:0]        dv_ru_reg   [QB];
    logic [DW-1:0]        dv_rv_reg   [QB];
    logic [QB-1:0]        dv_qu_reg   [QB];
    logic [QB-1:0]        dv_qv_reg   [QB];
    logic                 dv_ou_reg   [QB];
    logic                 dv_ov_reg   [QB];

    for (genvar i = 0; i < QB; i++)
    begin : g_div
        localparam int K = QB - 1 - i;
        logic            vin;
        lpc_pkg::meta_t  min;
        logic [SW-1:0]   din;
        logic [DW-1:0]   ru_in;
        logic [DW-1:0]   rv_in;
        logic [QB-1:0]   qu_in;
        logic [QB-1:0]   qv_in;
        logic            ou_in;
        logic            ov_in;
        logic [DW-1:0]   ds;
        logic            ge_u;
        logic            ge_v;

        if (i == 0)
        begin : g_first
            always_comb
            begin
                vin   = s3_vld_reg;
                min   = s3_meta_reg;
                din   = s3_mag_reg[2];
                ru_in = DW'(s3_mag_reg[0]);
                rv_in = DW'(s3_mag_reg[1]);
                qu_in = '0;
                qv_in = '0;
                ou_in = DW'(s3_mag_reg[0]) >= (DW'(s3_mag_reg[2]) << QB);
                ov_in = DW'(s3_mag_reg[1]) >= (DW'(s3_mag_reg[2]) << QB);
            end
        end
        else
        begin : g_next
            always_comb
            begin
                vin   = dv_vld_reg[i-1];
                min   = dv_meta_reg[i-1];
                din   = dv_d_reg[i-1];
                ru_in = dv_ru_reg[i-1];
                rv_in = dv_rv_reg[i-1];
                qu_in = dv_qu_reg[i-1];
                qv_in = dv_qv_reg[i-1];
                ou_in = dv_ou_reg[i-1];
                ov_in = dv_ov_reg[i-1];
            end
        end

        assign ds   = DW'(din) << K;
        assign ge_u = ru_in >= ds;
        assign ge_v = rv_in >= ds;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[i] <= 1'b0;
            end
            else
            begin
                dv_vld_reg[i] <= vin;
            end
        end

        always_ff @(posedge clk)
        begin
            dv_meta_reg[i] <= min;
            dv_d_reg[i]    <= din;
            dv_ru_reg[i]   <= ge_u ? ru_in - ds : ru_in;
            dv_rv_reg[i]   <= ge_v ? rv_in - ds : rv_in;
            dv_qu_reg[i]   <= {qu_in[QB-2:0], ge_u};
            dv_qv_reg[i]   <= {qv_in[QB-2:0], ge_v};
            dv_ou_reg[i]   <= ou_in;
            dv_ov_reg[i]   <= ov_in;
        end
    end

    // Final stage: range checks and store address
    lpc_pkg::meta_t fm;
    logic [QB-1:0]  qu;
    logic [QB-1:0]  qv;
    logic           pt;
    logic           u_ok;
    logic           v_ok;
    logic           vis;
    logic           wr;
    logic [AW-1:0]  row_sel;
    logic [AW-1:0]  col_sel;
    logic [AW-1:0]  addr;
    logic           fin_vld_reg;
    logic [EW-1:0]  fin_entry_reg;

    always_comb
    begin
        fm   = dv_meta_reg[QB-1];
        qu   = dv_qu_reg[QB-1];
        qv   = dv_qv_reg[QB-1];
        pt   = (fm.kind == lpc_pkg::KIND_POINT);
        u_ok = !dv_ou_reg[QB-1] && ((qu == '0) || (fm.su == fm.sw))
               && (32'(qu) < 32'(iw_reg)) && (32'(qu) < 32'(MAX_WIDTH));
        v_ok = !dv_ov_reg[QB-1] && ((qv == '0) || (fm.sv == fm.sw))
               && (32'(qv) < 32'(ih_reg)) && (32'(qv) < 32'(MAX_HEIGHT));
        vis  = pt && !fm.origin && !fm.wzero && !fm.dneg && u_ok && v_ok;
        wr   = !pt && (32'(fm.col) < 32'(MAX_WIDTH)) && (32'(fm.row) < 32'(MAX_HEIGHT));
        row_sel = pt ? AW'(qv) : AW'(fm.row);
        col_sel = pt ? AW'(qu) : AW'(fm.col);
        addr = row_sel * AW'(MAX_WIDTH) + col_sel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_vld_reg <= 1'b0;
        end
        else
        begin
            fin_vld_reg <= dv_vld_reg[QB-1];
        end
    end

    always_ff @(posedge clk)
    begin
        fin_entry_reg <= {pt, vis, wr, addr, fm.rgb};
    end

    assign push  = fin_vld_reg;
    assign entry = fin_entry_reg;

endmodule

>>> sv/lpc_back.sv
// Back part: image store, point colour lookup and result register.
// Depends on lpc_pkg only through the entry layout set by the top level.
module lpc_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 512,
    parameter int AW         = 19,
    parameter int EW         = 46
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  logic [EW-1:0] q_entry,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    red,
    output logic [7:0]    green,
    output logic [7:0]    blue,
    output logic          in_view
);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

    logic [23:0]   mem_q [DEPTH];
    logic          e_pt;
    logic          e_vis;
    logic          e_wr;
    logic [AW-1:0] e_addr;
    logic [23:0]   e_rgb;
    logic          s1_vld_reg;
    logic          s1_vis_reg;
    logic [23:0]   rdata_reg;

    assign {e_pt, e_vis, e_wr, e_addr, e_rgb} = q_entry;

    // Take the next item when the result stage is free or being drained
    assign q_pop = q_valid && (!s1_vld_reg || out_ready);

    // Write pixels, read colours of visible points
    always_ff @(posedge clk)
    begin
        if (q_pop && !e_pt && e_wr)
        begin
            mem_q[e_addr] <= e_rgb;
        end
        if (q_pop && e_pt && e_vis)
        begin
            rdata_reg <= mem_q[e_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s1_vis_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            s1_vld_reg <= e_pt;
            s1_vis_reg <= e_vis;
        end
        else if (out_ready)
        begin
            s1_vld_reg <= 1'b0;
        end
    end

    assign out_valid = s1_vld_reg;
    assign in_view   = s1_vis_reg;
    assign red       = s1_vis_reg ? rdata_reg[23:16] : 8'd0;
    assign green     = s1_vis_reg ? rdata_reg[15:8]  : 8'd0;
    assign blue      = s1_vis_reg ? rdata_reg[7:0]   : 8'd0;

endmodule

>>> sv/lidar_point_colorizer_top.sv
// Top level of the lidar point colorizer: front, queue and back joined by credit flow.
// Depends on lpc_pkg, lpc_front, lpc_fifo and lpc_back.
//
//   channel   signals                          direction
//   in        in_valid/in_ready + item fields  into block
//   out       out_valid/out_ready + colour     out of block
//   cfg       cfg_we, cfg_index, cfg_data      into block, write only
//
// One item per cycle while in_ready is high; a point result passes the input, product, sum and sign
// stages, the one-bit-per-stage divider chain, the final stage, the queue and the result register.
// Pixel items pass the same path so writes and reads stay in order; they give no result.
// in_ready drops when 32 items sit in the front pipeline and queue together.
// Reset clears control state and loads the image size registers; the image store holds
// no reset value.
module lidar_point_colorizer_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 512
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic [9:0]         pixel_col,
    input  logic [8:0]         pixel_row,
    input  logic [7:0]         pixel_red,
    input  logic [7:0]         pixel_green,
    input  logic [7:0]         pixel_blue,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         red,
    output logic [7:0]         green,
    output logic [7:0]         blue,
    output logic               in_view
);
    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int EW = 3 + AW + 24;
    localparam int CW = $clog2(lpc_pkg::QDEPTH) + 1;

    logic          acc;
    logic          q_push;
    logic [EW-1:0] q_din;
    logic          q_pop;
    logic [EW-1:0] q_dout;
    logic          q_valid;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;

    // Admit an item only while a queue slot is reserved for it
    assign in_ready = (cnt_reg < CW'(lpc_pkg::QDEPTH));
    assign acc      = in_valid && in_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (acc && !q_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (q_pop && !acc)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    lpc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW),
        .EW         (EW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .acc         (acc),
        .kind        (kind),
        .pixel_col   (pixel_col),
        .pixel_row   (pixel_row),
        .pixel_red   (pixel_red),
        .pixel_green (pixel_green),
        .pixel_blue  (pixel_blue),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_z     (point_z),
        .push        (q_push),
        .entry       (q_din)
    );

    lpc_fifo #(
        .W     (EW),
        .DEPTH (lpc_pkg::QDEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .din       (q_din),
        .pop       (q_pop),
        .dout      (q_dout),
        .not_empty (q_valid)
    );

    lpc_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW),
        .EW         (EW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_dout),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .in_view   (in_view)
    );

    // Items in flight never exceed the queue depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(lpc_pkg::QDEPTH))
        else $error("credit count above queue depth");
    a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
        acc && !q_pop |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("credit count missed an item");
    a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> cnt_reg != '0)
        else $error("pop with no item in flight");

endmodule

>>> verif/tb_lidar_point_colorizer_top.sv
// Testbench of the lidar point colorizer: pixel writes, point projection and colour lookup.
// Depends on lpc_pkg and lidar_point_colorizer_top; a local predictor checks every result.
module tb_lidar_point_colorizer_top;

    localparam int MAXW = 1024;
    localparam int MAXH = 512;
    localparam int SETTLE = 40;
    localparam longint LIMIT = 3000000;
    localparam longint ONE_Q16 = 65536;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       in_view;
    } colour_t;

    typedef struct {
        logic        kind;
        logic [9:0]  col;
        logic [8:0]  row;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } item_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [63:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               kind = lpc_pkg::KIND_PIXEL;
    logic [9:0]         pixel_col = '0;
    logic [8:0]         pixel_row = '0;
    logic [7:0]         pixel_red = '0;
    logic [7:0]         pixel_green = '0;
    logic [7:0]         pixel_blue = '0;
    logic signed [31:0] point_x = '0;
    logic signed [31:0] point_y = '0;
    logic signed [31:0] point_z = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               in_view;

    // Predictor state
    logic [63:0] proj_m [6];
    logic [10:0] width_m;
    logic [9:0]  height_m;
    logic [23:0] frame_m [int];
    colour_t     colour_q [$];
    int          fails = 0;
    bit          no_idle = 0;
    longint      cycles = 0;

    lidar_point_colorizer_top u_dut (.*);

    always #5 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("%0t timeout", $time);
            $display("Verification failed");
            $finish;
        end
    end

    function automatic longint coef(int r, int c);
        logic [63:0] reg_v;
        logic [31:0] half;
        reg_v = proj_m[r * 2 + c / 2];
        half = (c % 2) ? reg_v[63:32] : reg_v[31:0];
        return longint'($signed(half));
    endfunction

    // Floored Q.16 products plus translation term
    function automatic longint project_row(int r, longint x, longint y, longint z);
        return ((coef(r, 0) * x) >>> 16) + ((coef(r, 1) * y) >>> 16)
             + ((coef(r, 2) * z) >>> 16) + coef(r, 3);
    endfunction

    // Work out the colour of one point; hit flags a store read at addr
    function automatic colour_t colour_point(logic [31:0] xi, logic [31:0] yi, logic [31:0] zi,
                                             output int addr, output bit hit);
        colour_t c;
        longint x, y, z, uu, vv, ww, u, v, depth, wl, hl;
        c = '{8'd0, 8'd0, 8'd0, 1'b0};
        hit = 0;
        addr = 0;
        x = longint'($signed(xi));
        y = longint'($signed(yi));
        z = longint'($signed(zi));
        if (x == 0 && y == 0 && z == 0)
            return c;
        uu = project_row(0, x, y, z);
        vv = project_row(1, x, y, z);
        ww = project_row(2, x, y, z);
        if (ww == 0)
            return c;
        u = uu / ww;
        v = vv / ww;
        depth = ww / ONE_Q16;
        wl = (width_m > MAXW) ? MAXW : width_m;
        hl = (height_m > MAXH) ? MAXH : height_m;
        if (depth < 0 || u < 0 || v < 0 || u >= wl || v >= hl)
            return c;
        hit = 1;
        addr = int'(v) * MAXW + int'(u);
        if (frame_m.exists(addr))
            c = '{frame_m[addr][23:16], frame_m[addr][15:8], frame_m[addr][7:0], 1'b1};
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Compare each result with the oldest expectation; stall at random
    always @(posedge clk)
    begin
        colour_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (colour_q.size() == 0)
            begin
                fails++;
                $display("%0t unexpected result rgb=%h%h%h in_view=%b",
                         $time, red, green, blue, in_view);
            end
            else
            begin
                e = colour_q.pop_front();
                if (red !== e.red)
                begin
                    fails++;
                    $display("%0t red exp %h act %h", $time, e.red, red);
                end
                if (green !== e.green)
                begin
                    fails++;
                    $display("%0t green exp %h act %h", $time, e.green, green);
                end
                if (blue !== e.blue)
                begin
                    fails++;
                    $display("%0t blue exp %h act %h", $time, e.blue, blue);
                end
                if (in_view !== e.in_view)
                begin
                    fails++;
                    $display("%0t in_view exp %b act %b", $time, e.in_view, in_view);
                end
            end
        end
        out_ready <= no_idle ? 1'b1 : (pick_gap() == 0);
    end

    // Send one item, predict it at acceptance, then idle for a random gap that may be zero
    task automatic send_item(item_t it);
        int addr;
        bit hit;
        int gap;
        kind <= it.kind;
        pixel_col <= it.col;
        pixel_row <= it.row;
        pixel_red <= it.r;
        pixel_green <= it.g;
        pixel_blue <= it.b;
        point_x <= it.x;
        point_y <= it.y;
        point_z <= it.z;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (it.kind == lpc_pkg::KIND_PIXEL)
            frame_m[int'(it.row) * MAXW + int'(it.col)] = {it.r, it.g, it.b};
        else
            colour_q.insert(colour_q.size(), colour_point(it.x, it.y, it.z, addr, hit));
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_pixel(int col, int row, logic [23:0] rgb);
        item_t it;
        it = '{lpc_pkg::KIND_PIXEL, col[9:0], row[8:0], rgb[23:16], rgb[15:8], rgb[7:0],
               $urandom(), $urandom(), $urandom()};
        send_item(it);
    endtask

    // Write the looked-up pixel first where the point would read an empty entry
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        item_t it;
        int addr;
        bit hit;
        colour_t c;
        c = colour_point(x, y, z, addr, hit);
        if (hit && !frame_m.exists(addr))
            send_pixel(addr % MAXW, addr / MAXW, 24'($urandom()));
        it = '{lpc_pkg::KIND_POINT, 10'($urandom()), 9'($urandom()), 8'($urandom()),
               8'($urandom()), 8'($urandom()), x, y, z};
        send_item(it);
    endtask

    // Wait for every result, then let the pipeline empty
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (colour_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // One register write; cfg_we drops again before the task returns
    task automatic cfg_write(logic [2:0] idx, logic [63:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx <= lpc_pkg::CFG_PROJ_LAST)
            proj_m[idx] = data;
        else if (idx == lpc_pkg::CFG_WIDTH)
            width_m = data[10:0];
        else
            height_m = data[9:0];
        @(posedge clk);
    endtask

    // Pinhole camera, identity rotation: focal f and centre cx, cy in Q16.16
    task automatic set_camera(longint f, longint cx, longint cy, longint tz);
        cfg_write(lpc_pkg::CFG_PROJ_R0_C01, {32'd0, f[31:0]});
        cfg_write(lpc_pkg::CFG_PROJ_R0_C23, {32'd0, cx[31:0]});
        cfg_write(lpc_pkg::CFG_PROJ_R1_C01, {f[31:0], 32'd0});
        cfg_write(lpc_pkg::CFG_PROJ_R1_C23, {32'd0, cy[31:0]});
        cfg_write(lpc_pkg::CFG_PROJ_R2_C01, 64'd0);
        cfg_write(lpc_pkg::CFG_PROJ_R2_C23, {tz[31:0], 32'h0001_0000});
    endtask

    // Point that should land near pixel (u, v) at depth z under the camera
    task automatic aim_point(longint f, longint cx, longint cy, longint u, longint v,
                             longint z);
        longint x, y;
        x = ((u << 16) - cx) * z / f;
        y = ((v << 16) - cy) * z / f;
        send_point(x[31:0], y[31:0], z[31:0]);
    endtask

    task automatic test_reset_state();
        // Zero matrix after reset: W is zero for any point
        send_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        send_point(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
        send_point(32'd0, 32'd0, 32'd0);
        drain();
    endtask

    task automatic test_directed();
        longint f, cx, cy;
        f = 64'd100 << 16;
        cx = 64'd512 << 16;
        cy = 64'd256 << 16;
        set_camera(f, cx, cy, 0);
        cfg_write(lpc_pkg::CFG_WIDTH, 64'd1024);
        cfg_write(lpc_pkg::CFG_HEIGHT, 64'd512);
        send_pixel(1023, 511, 24'hffffff);
        send_pixel(0, 0, 24'h000000);
        send_pixel(0, 0, 24'h123456);
        // Corners of the image
        aim_point(f, cx, cy, 0, 0, 64'd4 << 16);
        aim_point(f, cx, cy, 1023, 511, 64'd4 << 16);
        aim_point(f, cx, cy, 1023, 0, 64'd2 << 16);
        aim_point(f, cx, cy, 0, 511, 64'd2 << 16);
        // Just outside on each side
        aim_point(f, cx, cy, -1, 10, 64'd4 << 16);
        aim_point(f, cx, cy, 10, -1, 64'd4 << 16);
        aim_point(f, cx, cy, 1024, 10, 64'd4 << 16);
        aim_point(f, cx, cy, 10, 512, 64'd4 << 16);
        // Point behind the camera and at the origin
        send_point(32'h0000_1000, 32'h0000_1000, 32'hfffe_0000);
        send_point(32'd0, 32'd0, 32'd0);
        // Extreme coordinates
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'd0, 32'd0, 32'h0000_0001);
        drain();
        // Image size at and beyond its limits
        cfg_write(lpc_pkg::CFG_WIDTH, 64'd2047);
        cfg_write(lpc_pkg::CFG_HEIGHT, 64'd1023);
        aim_point(f, cx, cy, 1023, 511, 64'd4 << 16);
        aim_point(f, cx, cy, 1024, 511, 64'd4 << 16);
        drain();
        cfg_write(lpc_pkg::CFG_WIDTH, 64'd0);
        cfg_write(lpc_pkg::CFG_HEIGHT, 64'd1);
        aim_point(f, cx, cy, 0, 0, 64'd4 << 16);
        drain();
        cfg_write(lpc_pkg::CFG_WIDTH, 64'd1);
        cfg_write(lpc_pkg::CFG_HEIGHT, 64'd0);
        aim_point(f, cx, cy, 0, 0, 64'd4 << 16);
        drain();
    endtask

    task automatic test_random_phases();
        longint f, cx, cy, tz, wi, hi, z;
        int r, n;
        for (int ph = 0; ph < 9; ph++)
        begin
            no_idle = (ph == 3);
            f = longint'($urandom_range(20 << 16, 400 << 16));
            wi = (ph == 0) ? 1 : (ph == 1) ? 1024 : (ph == 2) ? 2047 : $urandom_range(1, 1024);
            hi = (ph == 0) ? 1 : (ph == 1) ? 512 : (ph == 2) ? 1023 : $urandom_range(1, 512);
            cx = (wi > MAXW ? MAXW : wi) * 32768 + $urandom_range(0, 65535);
            cy = (hi > MAXH ? MAXH : hi) * 32768 + $urandom_range(0, 65535);
            tz = longint'($signed($urandom_range(0, 1 << 17))) - (1 << 16);
            set_camera(f, cx, cy, tz);
            cfg_write(lpc_pkg::CFG_WIDTH, wi);
            cfg_write(lpc_pkg::CFG_HEIGHT, hi);
            if (ph == 8)
                for (int i = 0; i < 6; i++)
                    cfg_write(i[2:0], {$urandom(), $urandom()});
            for (n = 0; n < 180; n++)
            begin
                r = $urandom_range(0, 99);
                z = longint'($urandom_range(1 << 12, 60 << 16));
                if (r < 70)
                    aim_point(f, cx, cy,
                              longint'($urandom_range(0, 1100)) - 20,
                              longint'($urandom_range(0, 560)) - 20,
                              ($urandom_range(0, 19) == 0) ? -z : z);
                else if (r < 85)
                    send_pixel($urandom_range(0, 1023), $urandom_range(0, 511),
                               24'($urandom()));
                else
                    send_point($urandom(), $urandom(), $urandom());
                // Hold off until every pending result is back
                if (n == 100)
                    drain();
            end
            drain();
        end
        no_idle = 0;
    endtask

    initial
    begin
        for (int i = 0; i < 6; i++)
            proj_m[i] = '0;
        width_m = lpc_pkg::WIDTH_RESET;
        height_m = lpc_pkg::HEIGHT_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE) @(posedge clk);
        test_reset_state();
        test_directed();
        test_random_phases();
        drain();
        if (fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
